>>> hw/rtl/seconds_to_calendar_date_defines.svh
// Assertion macros used by the checker of the calendar decoder.
`ifndef SECONDS_TO_CALENDAR_DATE_DEFINES_SVH
`define SECONDS_TO_CALENDAR_DATE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define STC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define STC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/stc_pkg.sv
package stc_pkg;

    // Pipeline depth from input transfer to output register.
    localparam int NUM_STAGES = 6;

    // Exact reciprocal multipliers: floor(x / d) = (x * Recip) >> Shift
    // for every x the datapath can present at that point.
    localparam logic [25:0] DAY_RECIP   = 26'd50903317;  // 1/675, x < 2^25
    localparam logic [9:0]  DAY_UNIT    = 10'd675;       // 86400 / 128
    localparam logic [15:0] YEAR_RECIP  = 16'd45965;     // 1/365, x < 2^16
    localparam logic [16:0] WEEK_RECIP  = 17'd74899;     // 1/7
    localparam logic [17:0] MIN_RECIP   = 18'd139811;    // 1/60, x < 86400
    localparam logic [11:0] HOUR_RECIP  = 12'd2185;      // 1/60, x < 1440

    localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;
    localparam logic [2:0]  EPOCH_WEEKDAY   = 3'd4;      // epoch day is a Thursday
    localparam logic [7:0]  EPOCH_YEAR_OFF  = 8'd70;     // 1970 - 1900
    localparam logic [7:0]  SKIP_LEAP_OFF   = 8'd131;    // year - 1 reaches 2100
    localparam logic [7:0]  NO_LEAP_YEAR    = 8'd200;    // 2100, not a leap year
    localparam logic [5:0]  SECS_PER_MIN    = 6'd60;

    // Month pick handed from the lookup to the pipeline.
    typedef struct packed {
        logic [3:0] month;
        logic [8:0] start;
    } month_sel_t;

    // Zero-based day of year on which month m begins.
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + 9'((m >= 4'd2) && leap);
    endfunction

endpackage

>>> hw/rtl/stc_month_lookup.sv
module stc_month_lookup (
    input  logic               [8:0] day_idx,
    input  logic                     leap,
    output stc_pkg::month_sel_t      sel
);
    import stc_pkg::*;

    // Compare against every month start in parallel; the last one passed wins.
    always_comb begin
        logic [8:0] first;
        sel.month = 4'd0;
        sel.start = 9'd0;
        for (int m = 1; m < 12; m++) begin
            first = month_start(4'(m), leap);
            if (day_idx >= first) begin
                sel.month = 4'(m);
                sel.start = first;
            end
        end
    end

endmodule

>>> hw/rtl/seconds_to_calendar_date.sv
// Calendar decoder for a 32-bit count of seconds since 1970-01-01 00:00:00.
//
// Input channel s_*: one seconds count per transfer (s_valid / s_ready).
// Output channel m_*: weekday, years since 1900, 1-based day of year, month,
// day of month, hour, minute and second of that count (m_valid / m_ready).
// Every input gives exactly one output, in order.
//
// Throughput: one item per cycle unless the output stalls; each stage holds
// reciprocal multiplications or add/compare steps, with a valid bit beside
// it.
//
// Stall: a full stage holds while its successor cannot load. s_ready drops only when
// all six stages hold data and m_ready is low; outputs hold until taken.
//
// Reset: aresetn low (synchronous) empties the pipeline; m_valid goes low.
module seconds_to_calendar_date (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_seconds_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_week_day,
    output logic [7:0]  m_years_since_1900,
    output logic [8:0]  m_day_of_year,
    output logic [3:0]  m_month_index,
    output logic [4:0]  m_month_day,
    output logic [4:0]  m_hour_of_day,
    output logic [5:0]  m_minute_of_hour,
    output logic [5:0]  m_second_of_minute
);
    import stc_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] valid_in;
    logic [NUM_STAGES-1:0] stage_ready;

    // Stage enables: a stage loads when empty or when its successor loads.
    always_comb begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign valid_in = {valid_reg[NUM_STAGES-2:0], s_valid};

    always_comb begin
        for (int i = 0; i < NUM_STAGES; i++) begin
            valid_next[i] = stage_ready[i] ? valid_in[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: day count = (seconds / 128) / 675.
    logic [50:0] day_prod;
    logic [15:0] day1_next, day1_reg;
    logic [16:0] tlow1_next, tlow1_reg;

    assign day_prod   = 51'(s_seconds_count[31:7]) * 51'(DAY_RECIP);
    assign day1_next  = day_prod[50:35];
    assign tlow1_next = s_seconds_count[16:0];

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            day1_reg  <= day1_next;
            tlow1_reg <= tlow1_next;
        end
    end

    // Stage 2: time of day, year offset estimate, weekday quotient.
    logic [25:0] unit_prod;
    logic [9:0]  unit_rem;
    logic [31:0] year_prod;
    logic [16:0] wk_sum;
    logic [33:0] wk_prod;
    logic [16:0] tod2_next, tod2_reg;
    logic [7:0]  yoff2_next, yoff2_reg;
    logic [2:0]  wkq2_next, wkq2_reg;
    logic [2:0]  wks2_next, wks2_reg;
    logic [15:0] day2_reg;

    assign unit_prod  = 26'(day1_reg) * 26'(DAY_UNIT);
    assign unit_rem   = tlow1_reg[16:7] - unit_prod[9:0];
    assign tod2_next  = {unit_rem, tlow1_reg[6:0]};
    assign year_prod  = 32'(day1_reg) * 32'(YEAR_RECIP);
    assign yoff2_next = year_prod[31:24];
    assign wk_sum     = {1'b0, day1_reg} + 17'(EPOCH_WEEKDAY);
    assign wk_prod    = 34'(wk_sum) * 34'(WEEK_RECIP);
    assign wkq2_next  = wk_prod[21:19];
    assign wks2_next  = wk_sum[2:0];

    always_ff @(posedge aclk) begin
        if (stage_ready[1]) begin
            tod2_reg  <= tod2_next;
            yoff2_reg <= yoff2_next;
            wkq2_reg  <= wkq2_next;
            wks2_reg  <= wks2_next;
            day2_reg  <= day1_reg;
        end
    end

    // Stage 3: total minutes of the day, days left after whole years, weekday.
    logic [34:0] min_prod;
    logic [16:0] yr_days;
    logic [5:0]  leap_cnt;
    logic        skip_leap;
    logic [16:0] elapsed;
    logic [16:0] days_diff;
    logic [10:0] mt3_next, mt3_reg;
    logic [9:0]  days3_next, days3_reg;
    logic [2:0]  wday3_next, wday3_reg;
    logic [16:0] tod3_reg;
    logic [7:0]  yoff3_reg;

    assign min_prod   = 35'(tod2_reg) * 35'(MIN_RECIP);
    assign mt3_next   = min_prod[33:23];
    assign yr_days    = 17'(yoff2_reg) * 17'(DAYS_PER_YEAR);
    assign leap_cnt   = 6'((9'(yoff2_reg) + 9'd1) >> 2);
    assign skip_leap  = (yoff2_reg >= SKIP_LEAP_OFF);
    assign elapsed    = yr_days + 17'(leap_cnt) - 17'(skip_leap);
    assign days_diff  = {1'b0, day2_reg} - elapsed;
    assign days3_next = days_diff[9:0];
    assign wday3_next = wks2_reg - 3'(wkq2_reg * 3'd7);

    always_ff @(posedge aclk) begin
        if (stage_ready[2]) begin
            mt3_reg   <= mt3_next;
            days3_reg <= days3_next;
            wday3_reg <= wday3_next;
            tod3_reg  <= tod2_reg;
            yoff3_reg <= yoff2_reg;
        end
    end

    // Stage 4: hour; step the year back once when the day count went negative.
    logic [22:0] hour_prod;
    logic        borrow;
    logic [9:0]  year_len_add;
    logic [9:0]  days_sum;
    logic [4:0]  hour4_next, hour4_reg;
    logic [7:0]  year4_next, year4_reg;
    logic        leap4_next, leap4_reg;
    logic [8:0]  days4_next, days4_reg;
    logic [10:0] mt4_reg;
    logic [5:0]  tod4_reg;
    logic [2:0]  wday4_reg;

    assign hour_prod    = 23'(mt3_reg) * 23'(HOUR_RECIP);
    assign hour4_next   = hour_prod[21:17];
    assign borrow       = days3_reg[9];
    assign year4_next   = yoff3_reg + EPOCH_YEAR_OFF - 8'(borrow);
    assign leap4_next   = (year4_next[1:0] == 2'b00) && (year4_next != NO_LEAP_YEAR);
    assign year_len_add = borrow ? (10'(DAYS_PER_YEAR) + 10'(leap4_next)) : 10'd0;
    assign days_sum     = days3_reg + year_len_add;
    assign days4_next   = days_sum[8:0];

    always_ff @(posedge aclk) begin
        if (stage_ready[3]) begin
            hour4_reg <= hour4_next;
            year4_reg <= year4_next;
            leap4_reg <= leap4_next;
            days4_reg <= days4_next;
            mt4_reg   <= mt3_reg;
            tod4_reg  <= tod3_reg[5:0];
            wday4_reg <= wday3_reg;
        end
    end

    // Stage 5: minute, second, month pick.
    logic [10:0]  hour_mins;
    logic [10:0]  min_diff;
    logic [5:0]   sec_sub;
    month_sel_t   month_sel;
    logic [5:0]   minute5_next, minute5_reg;
    logic [5:0]   second5_next, second5_reg;
    month_sel_t   month5_reg;
    logic [8:0]   days5_reg;
    logic [4:0]   hour5_reg;
    logic [7:0]   year5_reg;
    logic [2:0]   wday5_reg;

    assign hour_mins    = 11'(hour4_reg) * 11'(SECS_PER_MIN);
    assign min_diff     = mt4_reg - hour_mins;
    assign minute5_next = min_diff[5:0];
    assign sec_sub      = mt4_reg[5:0] * SECS_PER_MIN;
    assign second5_next = tod4_reg - sec_sub;

    stc_month_lookup u_month_lookup (
        .day_idx (days4_reg),
        .leap    (leap4_reg),
        .sel     (month_sel)
    );

    always_ff @(posedge aclk) begin
        if (stage_ready[4]) begin
            minute5_reg <= minute5_next;
            second5_reg <= second5_next;
            month5_reg  <= month_sel;
            days5_reg   <= days4_reg;
            hour5_reg   <= hour4_reg;
            year5_reg   <= year4_reg;
            wday5_reg   <= wday4_reg;
        end
    end

    // Stage 6: day of month and day of year; output register.
    logic [8:0] mday_full;
    logic [8:0] yday6_next, yday6_reg;
    logic [4:0] mday6_next, mday6_reg;
    logic [3:0] month6_reg;
    logic [4:0] hour6_reg;
    logic [5:0] minute6_reg;
    logic [5:0] second6_reg;
    logic [7:0] year6_reg;
    logic [2:0] wday6_reg;

    assign mday_full  = days5_reg - month5_reg.start + 9'd1;
    assign mday6_next = mday_full[4:0];
    assign yday6_next = days5_reg + 9'd1;

    always_ff @(posedge aclk) begin
        if (stage_ready[5]) begin
            yday6_reg   <= yday6_next;
            mday6_reg   <= mday6_next;
            month6_reg  <= month5_reg.month;
            hour6_reg   <= hour5_reg;
            minute6_reg <= minute5_reg;
            second6_reg <= second5_reg;
            year6_reg   <= year5_reg;
            wday6_reg   <= wday5_reg;
        end
    end

    assign s_ready            = stage_ready[0];
    assign m_valid            = valid_reg[NUM_STAGES-1];
    assign m_week_day         = wday6_reg;
    assign m_years_since_1900 = year6_reg;
    assign m_day_of_year      = yday6_reg;
    assign m_month_index      = month6_reg;
    assign m_month_day        = mday6_reg;
    assign m_hour_of_day      = hour6_reg;
    assign m_minute_of_hour   = minute6_reg;
    assign m_second_of_minute = second6_reg;

endmodule

>>> hw/rtl/stc_checker.sv
`include "seconds_to_calendar_date_defines.svh"

module stc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [31:0] s_seconds_count,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_week_day,
    input logic [7:0]  m_years_since_1900,
    input logic [8:0]  m_day_of_year,
    input logic [3:0]  m_month_index,
    input logic [4:0]  m_month_day,
    input logic [4:0]  m_hour_of_day,
    input logic [5:0]  m_minute_of_hour,
    input logic [5:0]  m_second_of_minute
);

    // A stalled result stays valid and keeps its day of year until it is taken.
    `STC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_day_of_year), "result dropped while stalled")

    // Back-pressure only while the output holds a result and stalls.
    `STC_ASSERT_NOW(a_full_stall, !s_ready, m_valid && !m_ready, "input blocked with room in pipeline")

    // Keep every field within its calendar range.
    `STC_ASSERT_NOW(a_field_range, m_valid, (m_week_day <= 3'd6) && (m_month_index <= 4'd11) && (m_hour_of_day <= 5'd23) && (m_minute_of_hour <= 6'd59) && (m_second_of_minute <= 6'd59) && (m_month_day >= 5'd1) && (m_day_of_year >= 9'd1) && (m_day_of_year <= 9'd366) && (m_years_since_1900 >= 8'd70) && (m_years_since_1900 <= 8'd206), "calendar field out of range")

    // The last representable instant lies in February 2106.
    `STC_ASSERT_NOW(a_last_year, m_valid && (m_years_since_1900 == 8'd206), m_month_index <= 4'd1, "date beyond the 32-bit range")

endmodule

bind seconds_to_calendar_date stc_checker u_stc_checker (.*);
